/* rtl/counting_semaphore_table_core_assert.svh */
// Assertion macros used by the semaphore table checker
`ifndef COUNTING_SEMAPHORE_TABLE_CORE_ASSERT_SVH
`define COUNTING_SEMAPHORE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled during rst
`define CST_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled during rst
`define CST_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/cst_pkg.sv */
// Shared types and constants for the counting semaphore table
package cst_pkg;

  // Table geometry
  localparam int NUM_SEMS = 32;
  localparam int SEM_W    = (NUM_SEMS > 2) ? $clog2(NUM_SEMS) : 1;
  localparam int PID_W    = 5;
  localparam int NUM_IDS  = 1 << PID_W;
  localparam int IDX_W    = 8;
  localparam int CNT_W    = 16;
  localparam int HDL_W    = 5;

  // Function codes
  localparam logic [1:0] FUNC_CREATE = 2'd0;
  localparam logic [1:0] FUNC_WAIT   = 2'd1;
  localparam logic [1:0] FUNC_SIGNAL = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_HDL = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  // Count limits
  localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
  localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};

  // One request transaction
  typedef struct packed {
    logic [1:0]              func;
    logic [IDX_W-1:0]        sem_index;
    logic signed [CNT_W-1:0] initial_count;
    logic [PID_W-1:0]        process_id;
  } req_t;

  // One response transaction
  typedef struct packed {
    logic [1:0]       status;
    logic [HDL_W-1:0] handle;
    logic             must_block;
    logic             wake_valid;
    logic [PID_W-1:0] wake_process;
  } rsp_t;

endpackage

/* rtl/cst_req_if.sv */
// Request channel: valid/ready with the operation payload
interface cst_req_if;
  logic                                     valid;
  logic                                     ready;
  logic [1:0]                               func;
  logic [cst_pkg::IDX_W-1:0]                sem_index;
  logic signed [cst_pkg::CNT_W-1:0]         initial_count;
  logic [cst_pkg::PID_W-1:0]                process_id;

  modport source (output valid, func, sem_index, initial_count, process_id,
                  input ready);
  modport sink (input valid, func, sem_index, initial_count, process_id,
                output ready);
endinterface

/* rtl/cst_rsp_if.sv */
// Response channel: valid/ready with the result payload
interface cst_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [cst_pkg::HDL_W-1:0]   handle;
  logic                        must_block;
  logic                        wake_valid;
  logic [cst_pkg::PID_W-1:0]   wake_process;

  modport source (output valid, status, handle, must_block, wake_valid, wake_process,
                  input ready);
  modport sink (input valid, status, handle, must_block, wake_valid, wake_process,
                output ready);
endinterface

/* rtl/cst_alloc.sv */
// Lowest-free-slot finder over the slot-in-use vector
module cst_alloc (
  input  logic [cst_pkg::NUM_SEMS-1:0] used,
  output logic                         found,
  output logic [cst_pkg::SEM_W-1:0]    slot
);

  // Scan from the top so the lowest free slot wins
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = cst_pkg::NUM_SEMS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        found = 1'b1;
        slot  = cst_pkg::SEM_W'(i);
      end
    end
  end

endmodule

/* rtl/cst_table.sv */
// Semaphore state table: counts, wait queues and the per-transaction update
module cst_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  cst_pkg::req_t item,
  output cst_pkg::rsp_t result
);

  // Control state, cleared by reset
  logic [cst_pkg::NUM_SEMS-1:0] slot_used;
  logic [cst_pkg::NUM_SEMS-1:0] queue_nonempty;

  // Payload state, meaningful only once written
  logic signed [cst_pkg::CNT_W-1:0] sem_count   [cst_pkg::NUM_SEMS];
  logic [cst_pkg::PID_W-1:0]        queue_head  [cst_pkg::NUM_SEMS];
  logic [cst_pkg::PID_W-1:0]        queue_tail  [cst_pkg::NUM_SEMS];
  logic [cst_pkg::PID_W-1:0]        next_waiter [cst_pkg::NUM_IDS];

  logic                             free_found;
  logic [cst_pkg::SEM_W-1:0]        free_slot;
  logic [cst_pkg::SEM_W-1:0]        sidx;
  logic [cst_pkg::SEM_W-1:0]        wr_slot;
  logic                             hdl_ok;
  logic signed [cst_pkg::CNT_W-1:0] cur_count;
  logic signed [cst_pkg::CNT_W-1:0] dec_count;
  logic signed [cst_pkg::CNT_W-1:0] inc_count;
  logic [cst_pkg::PID_W-1:0]        cur_head;
  logic [cst_pkg::PID_W-1:0]        cur_tail;
  logic                             cur_ne;
  logic [7:0]                       slot_wide;

  // Write controls
  logic                             we_count;
  logic signed [cst_pkg::CNT_W-1:0] count_wdata;
  logic                             we_head;
  logic [cst_pkg::PID_W-1:0]        head_wdata;
  logic                             we_tail;
  logic                             we_link;
  logic                             set_used;
  logic                             set_ne;
  logic                             clr_ne;

  cst_alloc u_alloc (
    .used  (slot_used),
    .found (free_found),
    .slot  (free_slot)
  );

  // Read side
  assign sidx      = item.sem_index[cst_pkg::SEM_W-1:0];
  assign hdl_ok    = (9'(item.sem_index) < 9'(cst_pkg::NUM_SEMS)) && slot_used[sidx];
  assign cur_count = sem_count[sidx];
  assign cur_head  = queue_head[sidx];
  assign cur_tail  = queue_tail[sidx];
  assign cur_ne    = queue_nonempty[sidx];
  assign dec_count = (cur_count != cst_pkg::CNT_MIN) ? cur_count - 16'sd1 : cur_count;
  assign inc_count = (cur_count != cst_pkg::CNT_MAX) ? cur_count + 16'sd1 : cur_count;
  assign slot_wide = 8'(free_slot);
  assign wr_slot   = (item.func == cst_pkg::FUNC_CREATE) ? free_slot : sidx;

  // Operation decode, result and write enables
  always_comb begin
    result      = '0;
    we_count    = 1'b0;
    count_wdata = item.initial_count;
    we_head     = 1'b0;
    head_wdata  = item.process_id;
    we_tail     = 1'b0;
    we_link     = 1'b0;
    set_used    = 1'b0;
    set_ne      = 1'b0;
    clr_ne      = 1'b0;
    case (item.func)
      cst_pkg::FUNC_CREATE: begin
        if (free_found) begin
          set_used      = 1'b1;
          we_count      = 1'b1;
          clr_ne        = 1'b1;
          result.handle = slot_wide[cst_pkg::HDL_W-1:0];
        end else begin
          result.status = cst_pkg::STAT_FULL;
        end
      end
      cst_pkg::FUNC_WAIT: begin
        if (!hdl_ok) begin
          result.status = cst_pkg::STAT_BAD_HDL;
        end else begin
          we_count    = 1'b1;
          count_wdata = dec_count;
          if (dec_count < 0) begin
            result.must_block = 1'b1;
            we_tail           = 1'b1;
            // append behind the tail, or start a fresh queue
            if (cur_ne) begin
              we_link = 1'b1;
            end else begin
              we_head = 1'b1;
              set_ne  = 1'b1;
            end
          end
        end
      end
      cst_pkg::FUNC_SIGNAL: begin
        if (!hdl_ok) begin
          result.status = cst_pkg::STAT_BAD_HDL;
        end else begin
          we_count    = 1'b1;
          count_wdata = inc_count;
          if ((inc_count <= 0) && cur_ne) begin
            result.wake_valid   = 1'b1;
            result.wake_process = cur_head;
            // pop the head; last waiter empties the queue
            if (cur_head == cur_tail) begin
              clr_ne = 1'b1;
            end else begin
              we_head    = 1'b1;
              head_wdata = next_waiter[cur_head];
            end
          end
        end
      end
      default: begin
        result.status = cst_pkg::STAT_BAD_HDL;
      end
    endcase
  end

  // Slot and queue occupancy flags
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used      <= '0;
      queue_nonempty <= '0;
    end else if (en) begin
      if (set_used) begin
        slot_used[wr_slot] <= 1'b1;
      end
      if (set_ne) begin
        queue_nonempty[wr_slot] <= 1'b1;
      end else if (clr_ne) begin
        queue_nonempty[wr_slot] <= 1'b0;
      end
    end
  end

  // Counts, queue pointers and waiter links
  always_ff @(posedge clk) begin
    if (en) begin
      if (we_count) begin
        sem_count[wr_slot] <= count_wdata;
      end
      if (we_head) begin
        queue_head[wr_slot] <= head_wdata;
      end
      if (we_tail) begin
        queue_tail[wr_slot] <= item.process_id;
      end
      if (we_link) begin
        next_waiter[cur_tail] <= item.process_id;
      end
    end
  end

endmodule

/* rtl/counting_semaphore_table_core.sv */
// The request passes through the input register and then the result register before its
// response transaction; a stalled response holds both registers.
// Throughput: one transaction per cycle while rsp is not stalled; the read-modify-write
// of one slot, its queue pointers and one waiter link completes as the stage advances.
// Reset (rst, synchronous): all slots free, all queues empty, both registers empty.
// Counts, queue pointers and waiter links need no reset and are valid once written.
module counting_semaphore_table_core (
  input logic       clk,
  input logic       rst,
  cst_req_if.sink   req,
  cst_rsp_if.source rsp
);

  logic          s1_valid;
  cst_pkg::req_t s1_item;
  logic          rsp_valid;
  cst_pkg::rsp_t rsp_item;
  cst_pkg::rsp_t table_result;
  logic          advance;

  // Stage advances when the result register is free or being drained
  assign advance   = s1_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item.func          <= req.func;
      s1_item.sem_index     <= req.sem_index;
      s1_item.initial_count <= req.initial_count;
      s1_item.process_id    <= req.process_id;
    end
  end

  cst_table u_table (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (s1_item),
    .result (table_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_item <= table_result;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_item.status;
  assign rsp.handle       = rsp_item.handle;
  assign rsp.must_block   = rsp_item.must_block;
  assign rsp.wake_valid   = rsp_item.wake_valid;
  assign rsp.wake_process = rsp_item.wake_process;

endmodule

/* rtl/cst_checker.sv */
// Port-level checks for the semaphore table core, bound to the top level
`include "counting_semaphore_table_core_assert.svh"

module cst_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [1:0]                rsp_status,
  input logic [cst_pkg::HDL_W-1:0] rsp_handle,
  input logic                      rsp_must_block,
  input logic                      rsp_wake_valid,
  input logic [cst_pkg::PID_W-1:0] rsp_wake_process
);

  // A stalled response stays valid and holds its status, handle and wake process
  `CST_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_handle) && $stable(rsp_wake_process), "response changed while stalled")

  // Blocking and waking only on successful operations, never both
  `CST_ASSERT_NOW(a_block_wake_ok, rsp_valid && (rsp_must_block || rsp_wake_valid), (rsp_status == cst_pkg::STAT_OK) && !(rsp_must_block && rsp_wake_valid), "block or wake on failed operation")

  // Failed operations carry zero result fields
  `CST_ASSERT_NOW(a_err_zero, rsp_valid && (rsp_status != cst_pkg::STAT_OK), (rsp_handle == '0) && !rsp_must_block && !rsp_wake_valid && (rsp_wake_process == '0), "nonzero fields on failed operation")

  // Nothing is presented right after reset
  `CST_ASSERT_NOW(a_reset_empty, $past(rst), !rsp_valid, "response valid after reset")

endmodule

bind counting_semaphore_table_core cst_checker u_cst_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_handle       (rsp.handle),
  .rsp_must_block   (rsp.must_block),
  .rsp_wake_valid   (rsp.wake_valid),
  .rsp_wake_process (rsp.wake_process)
);
